// ----- hdl/rsfp_pkg.sv -----
package rsfp_pkg;

  // Fixed frame layout.
  localparam logic [7:0] SYNC_BYTE    = 8'hAA;
  localparam int         SYNC_BYTES   = 4;
  localparam int         HEADER_BYTES = 10;
  localparam int         POINT_BYTES  = 15;
  localparam int         STAMP_BYTES  = 4;

  // Header byte positions after the sync run.
  localparam logic [7:0] POS_ADDRESS = 8'd4;
  localparam logic [7:0] POS_COMMAND = 8'd5;
  localparam logic [7:0] POS_LEN_LOW = 8'd8;
  localparam logic [7:0] POS_LEN_HIGH = 8'd9;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEVICE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_MEASURE_COMMAND = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_TICKS   = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // Input item kinds.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [2:0] {
    EV_POINT   = 3'd0,
    EV_GOOD    = 3'd1,
    EV_BADSUM  = 3'd2,
    EV_FORMAT  = 3'd3,
    EV_TIMEOUT = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [7:0]  measure_command;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    event_kind_t        event_kind;
    logic [3:0]         point_index;
    logic signed [15:0] distance;
    logic [15:0]        noise_level;
    logic [31:0]        peak_value;
    logic [7:0]         confidence_level;
    logic [31:0]        integration_time;
    logic signed [15:0] reference_tof;
    logic [31:0]        frame_timestamp;
    logic [31:0]        good_frames;
  } result_t;

endpackage

// ----- hdl/ranging_sensor_frame_parser_unit.sv -----
// Channel   Handshake            Payload
// in        in_valid / in_stall  req_type, data_byte
// out       out_valid / out_stall event_kind ... good_frames
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle unless out_stall holds the output; each result is registered in the output register.
// The input register holds one item while a stalled result waits in the output register.
// The parse itself is combinational: byte compare, 8-bit add and field select.
// Synchronous reset clears control state and loads register defaults.
// Configuration writes are always accepted (cfg_ready is held high).
module ranging_sensor_frame_parser_unit import rsfp_pkg::*; #(
  parameter int POINTS_PER_FRAME = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         event_kind,
  output logic [3:0]         point_index,
  output logic signed [15:0] distance,
  output logic [15:0]        noise_level,
  output logic [31:0]        peak_value,
  output logic [7:0]         confidence_level,
  output logic [31:0]        integration_time,
  output logic signed [15:0] reference_tof,
  output logic [31:0]        frame_timestamp,
  output logic [31:0]        good_frames,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t    cfg;
  item_t   hold_item;
  result_t result;
  result_t out_result;
  logic    hold_valid;
  logic    advance;
  logic    emit;
  logic    out_free;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address  <= '0;
      cfg.measure_command <= '0;
      cfg.timeout_ticks   <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS:  cfg.device_address  <= cfg_data[7:0];
        CFG_MEASURE_COMMAND: cfg.measure_command <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS:   cfg.timeout_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  rsfp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  rsfp_core #(
    .POINTS_PER_FRAME (POINTS_PER_FRAME)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .out_free   (out_free),
    .advance    (advance),
    .emit       (emit),
    .result     (result)
  );

  rsfp_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && emit),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  // Result fields.
  assign event_kind       = out_result.event_kind;
  assign point_index      = out_result.point_index;
  assign distance         = out_result.distance;
  assign noise_level      = out_result.noise_level;
  assign peak_value       = out_result.peak_value;
  assign confidence_level = out_result.confidence_level;
  assign integration_time = out_result.integration_time;
  assign reference_tof    = out_result.reference_tof;
  assign frame_timestamp  = out_result.frame_timestamp;
  assign good_frames      = out_result.good_frames;

endmodule

// ----- hdl/rsfp_in_stage.sv -----
module rsfp_in_stage import rsfp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  req_type,
  input  logic  [7:0] data_byte,
  input  logic  advance,
  output logic  hold_valid,
  output item_t hold_item
);

  logic accept;

  // The held item blocks a new one only when it cannot move on this cycle.
  assign in_stall = hold_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_item.req_type  <= req_type;
      hold_item.data_byte <= data_byte;
    end
  end

endmodule

// ----- hdl/rsfp_core.sv -----
module rsfp_core import rsfp_pkg::*; #(
  parameter int POINTS_PER_FRAME = 12
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    hold_valid,
  input  item_t   hold_item,
  input  logic    out_free,
  output logic    advance,
  output logic    emit,
  output result_t result
);

  localparam logic [7:0] EXPECTED_LENGTH = 8'(POINT_BYTES * POINTS_PER_FRAME + STAMP_BYTES);
  localparam logic [7:0] POINTS_END      = 8'(HEADER_BYTES + POINT_BYTES * POINTS_PER_FRAME);
  localparam logic [7:0] CHECKSUM_POS    = 8'(HEADER_BYTES + POINT_BYTES * POINTS_PER_FRAME
                                              + STAMP_BYTES);
  localparam logic [7:0] SYNC_END        = 8'(SYNC_BYTES);
  localparam logic [7:0] HEADER_END      = 8'(HEADER_BYTES);
  localparam logic [3:0] POINT_LAST      = 4'(POINT_BYTES - 1);

  // Frame control state.
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  length_low, length_low_next;
  logic [3:0]  point_counter, point_counter_next;
  logic [3:0]  point_offset, point_offset_next;
  logic [31:0] frame_counter, frame_counter_next;
  logic [15:0] idle_ticks, idle_ticks_next;

  // Byte stores for the point being assembled and the timestamp.
  logic [7:0]  point_bytes [POINT_BYTES-1];
  logic [7:0]  stamp_bytes [STAMP_BYTES];
  logic        point_we;
  logic        stamp_we;
  logic [1:0]  stamp_offset;
  logic [7:0]  stamp_diff;

  logic [7:0]  b;
  logic        restart;
  logic        header_ok;

  assign b          = hold_item.data_byte;
  assign stamp_diff = byte_position - POINTS_END;
  assign stamp_offset = stamp_diff[1:0];
  assign advance    = hold_valid && (!emit || out_free);

  // Next-state and result logic for the held item.
  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    length_low_next    = length_low;
    point_counter_next = point_counter;
    point_offset_next  = point_offset;
    frame_counter_next = frame_counter;
    idle_ticks_next    = idle_ticks;
    restart            = 1'b0;
    point_we           = 1'b0;
    stamp_we           = 1'b0;
    header_ok          = 1'b1;
    emit               = 1'b0;
    result             = '0;
    result.event_kind  = EV_POINT;

    if (hold_item.req_type == REQ_TICK) begin
      if (idle_ticks != '1) begin
        idle_ticks_next = idle_ticks + 16'd1;
      end
    end else if (idle_ticks > cfg.timeout_ticks) begin
      idle_ticks_next   = '0;
      restart           = 1'b1;
      emit              = 1'b1;
      result.event_kind = EV_TIMEOUT;
    end else begin
      idle_ticks_next = '0;
      if (byte_position < SYNC_END) begin
        // Sync run.
        if (b == SYNC_BYTE) begin
          byte_position_next = byte_position + 8'd1;
        end else begin
          restart           = 1'b1;
          emit              = 1'b1;
          result.event_kind = EV_FORMAT;
        end
      end else if (byte_position < HEADER_END) begin
        // Header: address, command, ignored offset, length.
        if (byte_position == POS_ADDRESS) begin
          header_ok = (b == cfg.device_address);
        end else if (byte_position == POS_COMMAND) begin
          header_ok = (b == cfg.measure_command);
        end else if (byte_position == POS_LEN_LOW) begin
          length_low_next = b;
        end else if (byte_position == POS_LEN_HIGH) begin
          header_ok = (b == 8'd0) && (length_low == EXPECTED_LENGTH);
        end
        if (header_ok) begin
          running_sum_next   = running_sum + b;
          byte_position_next = byte_position + 8'd1;
        end else begin
          restart           = 1'b1;
          emit              = 1'b1;
          result.event_kind = EV_FORMAT;
        end
      end else if (byte_position < POINTS_END) begin
        // Measurement points; the last byte completes and emits one.
        running_sum_next   = running_sum + b;
        byte_position_next = byte_position + 8'd1;
        if (point_offset == POINT_LAST) begin
          point_offset_next       = '0;
          point_counter_next      = point_counter + 4'd1;
          emit                    = 1'b1;
          result.point_index      = point_counter;
          result.distance         = {point_bytes[1], point_bytes[0]};
          result.noise_level      = {point_bytes[3], point_bytes[2]};
          result.peak_value       = {point_bytes[7], point_bytes[6],
                                     point_bytes[5], point_bytes[4]};
          result.confidence_level = point_bytes[8];
          result.integration_time = {point_bytes[12], point_bytes[11],
                                     point_bytes[10], point_bytes[9]};
          result.reference_tof    = {b, point_bytes[13]};
        end else begin
          point_we          = 1'b1;
          point_offset_next = point_offset + 4'd1;
        end
      end else if (byte_position < CHECKSUM_POS) begin
        // Timestamp bytes.
        stamp_we           = 1'b1;
        running_sum_next   = running_sum + b;
        byte_position_next = byte_position + 8'd1;
      end else begin
        // Checksum byte closes the frame either way.
        restart                = 1'b1;
        emit                   = 1'b1;
        result.frame_timestamp = {stamp_bytes[3], stamp_bytes[2],
                                  stamp_bytes[1], stamp_bytes[0]};
        if (b == running_sum) begin
          frame_counter_next = frame_counter + 32'd1;
          result.event_kind  = EV_GOOD;
        end else begin
          result.event_kind  = EV_BADSUM;
        end
      end
    end

    if (restart) begin
      byte_position_next = '0;
      running_sum_next   = '0;
      length_low_next    = '0;
      point_counter_next = '0;
      point_offset_next  = '0;
    end

    result.good_frames = frame_counter_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
      length_low    <= '0;
      point_counter <= '0;
      point_offset  <= '0;
      frame_counter <= '0;
      idle_ticks    <= '0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      length_low    <= length_low_next;
      point_counter <= point_counter_next;
      point_offset  <= point_offset_next;
      frame_counter <= frame_counter_next;
      idle_ticks    <= idle_ticks_next;
    end
  end

  // Byte stores; every byte is written before it is read within a frame.
  always_ff @(posedge clk) begin
    if (advance && point_we) begin
      point_bytes[point_offset] <= b;
    end
    if (advance && stamp_we) begin
      stamp_bytes[stamp_offset] <= b;
    end
  end

  // The checksum only starts after the sync run.
  a_sum_clear_in_sync: assert property (@(posedge clk) disable iff (rst)
    (byte_position < SYNC_END) |-> (running_sum == 8'd0))
    else $error("running sum nonzero during sync");

  // Position never passes the checksum byte.
  a_position_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= CHECKSUM_POS)
    else $error("byte position beyond checksum");

  // The point byte offset stays aligned with the point area.
  a_offset_idle: assert property (@(posedge clk) disable iff (rst)
    (byte_position <= HEADER_END || byte_position >= POINTS_END) |-> (point_offset == 4'd0))
    else $error("point offset out of step with frame position");

  // No more points are counted than a frame holds.
  a_point_count: assert property (@(posedge clk) disable iff (rst)
    {1'b0, point_counter} <= 5'(POINTS_PER_FRAME))
    else $error("point counter overrun");

  // A result is only produced while the following stage can take it.
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |-> out_free)
    else $error("result produced with no room");

endmodule

// ----- hdl/rsfp_out_stage.sv -----
module rsfp_out_stage import rsfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_result
);

  // The register can take a new result when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= result;
    end
  end

endmodule

// ----- dv/frame_event_checker.sv -----
module frame_event_checker import rsfp_pkg::*; #(
  parameter int POINTS_PER_FRAME = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               req_type,
  input  logic [7:0]         data_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         event_kind,
  input  logic [3:0]         point_index,
  input  logic signed [15:0] distance,
  input  logic [15:0]        noise_level,
  input  logic [31:0]        peak_value,
  input  logic [7:0]         confidence_level,
  input  logic [31:0]        integration_time,
  input  logic signed [15:0] reference_tof,
  input  logic [31:0]        frame_timestamp,
  input  logic [31:0]        good_frames,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 outstanding
);

  // Frame geometry derived from the number of points.
  localparam int FRAME_LENGTH = POINT_BYTES * POINTS_PER_FRAME + 4;
  localparam int POINTS_END   = HEADER_BYTES + POINT_BYTES * POINTS_PER_FRAME;
  localparam int CHECKSUM_POS = POINTS_END + STAMP_BYTES;

  // Shadow copy of the configuration registers.
  logic [7:0]   want_address;
  logic [7:0]   want_command;
  logic [15:0]  idle_limit;

  // Shadow copy of the parser state.
  logic [7:0]   byte_pos;
  logic [7:0]   frame_sum;
  logic [7:0]   len_low;
  logic [3:0]   point_count;
  logic [127:0] point_bytes;
  logic [31:0]  stamp;
  logic [31:0]  good_count;
  logic [15:0]  idle_count;

  result_t event_queue[$];
  result_t predicted;
  result_t oldest;
  bit      emits;
  int      mismatches = 0;

  function automatic void restart_frame();
    byte_pos    = '0;
    frame_sum   = '0;
    len_low     = '0;
    point_count = '0;
  endfunction

  // Advance the shadow parser by one item and form the event it raises, if any.
  task automatic parse_item(input logic kind, input logic [7:0] b,
                            output bit raised, output result_t ev);
    int  k;
    bit  header_ok;
    raised = 1'b0;
    ev     = '0;
    if (kind == REQ_TICK) begin
      if (idle_count != 16'hFFFF) idle_count++;
      return;
    end
    if (idle_count > idle_limit) begin
      // The line went quiet too long: drop the byte and start over.
      idle_count = '0;
      restart_frame();
      raised        = 1'b1;
      ev.event_kind = EV_TIMEOUT;
    end else begin
      idle_count = '0;
      if (byte_pos < SYNC_BYTES) begin
        if (b == SYNC_BYTE) begin
          byte_pos++;
        end else begin
          restart_frame();
          raised        = 1'b1;
          ev.event_kind = EV_FORMAT;
        end
      end else if (byte_pos < HEADER_BYTES) begin
        header_ok = 1'b1;
        case (byte_pos)
          POS_ADDRESS:  header_ok = (b == want_address);
          POS_COMMAND:  header_ok = (b == want_command);
          POS_LEN_LOW:  len_low = b;
          POS_LEN_HIGH: header_ok = (b == 8'h00) && (int'(len_low) == FRAME_LENGTH);
          default: ;
        endcase
        if (!header_ok) begin
          restart_frame();
          raised        = 1'b1;
          ev.event_kind = EV_FORMAT;
        end else begin
          frame_sum = frame_sum + b;
          byte_pos++;
        end
      end else if (byte_pos < POINTS_END) begin
        // Point bytes land little-endian in one wide assembly register.
        k = (int'(byte_pos) - HEADER_BYTES) % POINT_BYTES;
        frame_sum = frame_sum + b;
        byte_pos++;
        if (k == 0) point_bytes = '0;
        point_bytes[k*8 +: 8] = b;
        if (k == POINT_BYTES - 1) begin
          raised              = 1'b1;
          ev.event_kind       = EV_POINT;
          ev.point_index      = point_count;
          ev.distance         = point_bytes[15:0];
          ev.noise_level      = point_bytes[31:16];
          ev.peak_value       = point_bytes[63:32];
          ev.confidence_level = point_bytes[71:64];
          ev.integration_time = point_bytes[103:72];
          ev.reference_tof    = point_bytes[119:104];
          point_count++;
        end
      end else if (byte_pos < CHECKSUM_POS) begin
        k = int'(byte_pos) - POINTS_END;
        if (k == 0) stamp = '0;
        stamp[k*8 +: 8] = b;
        frame_sum = frame_sum + b;
        byte_pos++;
      end else begin
        // Checksum byte closes the frame either way.
        raised = 1'b1;
        if (b == frame_sum) begin
          good_count++;
          ev.event_kind = EV_GOOD;
        end else begin
          ev.event_kind = EV_BADSUM;
        end
        restart_frame();
        ev.frame_timestamp = stamp;
      end
    end
    if (raised) ev.good_frames = good_count;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Track register writes and accepted items, then compare each result transaction.
  always @(posedge clk) begin
    if (rst) begin
      want_address = '0;
      want_command = '0;
      idle_limit   = TIMEOUT_RESET;
      restart_frame();
      point_bytes  = '0;
      stamp        = '0;
      good_count   = '0;
      idle_count   = '0;
      event_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEVICE_ADDRESS:  want_address = cfg_data[7:0];
          CFG_MEASURE_COMMAND: want_command = cfg_data[7:0];
          CFG_TIMEOUT_TICKS:   idle_limit   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        parse_item(req_type, data_byte, emits, predicted);
        if (emits) event_queue.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (event_queue.size() == 0) begin
          $error("event_kind: expected no result, actual 0x%0h", event_kind);
          mismatches++;
        end else begin
          oldest = event_queue.pop_front();
          check_field("event_kind", oldest.event_kind, event_kind);
          check_field("point_index", oldest.point_index, point_index);
          check_field("distance", oldest.distance, distance);
          check_field("noise_level", oldest.noise_level, noise_level);
          check_field("peak_value", oldest.peak_value, peak_value);
          check_field("confidence_level", oldest.confidence_level, confidence_level);
          check_field("integration_time", oldest.integration_time, integration_time);
          check_field("reference_tof", oldest.reference_tof, reference_tof);
          check_field("frame_timestamp", oldest.frame_timestamp, frame_timestamp);
          check_field("good_frames", oldest.good_frames, good_frames);
        end
      end
    end
    outstanding <= event_queue.size();
    fail_count  <= mismatches;
  end

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import rsfp_pkg::*;

  localparam int POINTS       = 12;
  localparam int FRAME_LEN    = POINT_BYTES * POINTS + 4;
  localparam int FRAME_BYTES  = HEADER_BYTES + POINT_BYTES * POINTS + STAMP_BYTES + 1;
  localparam int RANDOM_ITEMS = 1850;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STUCK_LIMIT  = 2000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               req_type  = 1'b0;
  logic [7:0]         data_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         event_kind;
  logic [3:0]         point_index;
  logic signed [15:0] distance;
  logic [15:0]        noise_level;
  logic [31:0]        peak_value;
  logic [7:0]         confidence_level;
  logic [31:0]        integration_time;
  logic signed [15:0] reference_tof;
  logic [31:0]        frame_timestamp;
  logic [31:0]        good_frames;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 2'd0;
  logic [15:0]        cfg_data  = 16'h0000;
  int                 fail_count;
  int                 outstanding;

  // Stimulus control shared with the receiver.
  bit         no_idle = 1'b0;
  bit         hold_off_request = 1'b0;
  int         tick_pct = 0;
  int         items_sent = 0;
  logic [7:0] cur_address = 8'h00;
  logic [7:0] cur_command = 8'h00;

  ranging_sensor_frame_parser_unit #(.POINTS_PER_FRAME(POINTS)) dut (.*);

  frame_event_checker #(.POINTS_PER_FRAME(POINTS)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int run;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        run = idle_len();
        if (run == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (run) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Ends the run when no transaction of any kind happens for too long.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one item and hold it until the block takes it.
  task automatic send_item(input logic kind, input logic [7:0] value);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    data_byte <= value;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all registers; unused upper bits of the byte registers are random.
  task automatic program_regs(input logic [7:0] addr, input logic [7:0] cmd,
                              input logic [15:0] ticks);
    logic [7:0] pad_a;
    logic [7:0] pad_c;
    pad_a = 8'($urandom);
    pad_c = 8'($urandom);
    settle();
    cfg_write(CFG_DEVICE_ADDRESS, {pad_a, addr});
    cfg_write(CFG_MEASURE_COMMAND, {pad_c, cmd});
    cfg_write(CFG_TIMEOUT_TICKS, ticks);
    cfg_valid <= 1'b0;
    cur_address = addr;
    cur_command = cmd;
  endtask

  // Build a frame with a correct checksum, optionally damage it, and send it.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [15:0] len, input int damage_at,
                            input bit bad_sum, input fill_t fill);
    logic [7:0] frame_bytes [0:FRAME_BYTES-1];
    logic [7:0] sum;
    logic [7:0] delta;
    int         i;
    for (i = 0; i < SYNC_BYTES; i++) frame_bytes[i] = SYNC_BYTE;
    frame_bytes[POS_ADDRESS]  = addr;
    frame_bytes[POS_COMMAND]  = cmd;
    frame_bytes[6]            = 8'($urandom);
    frame_bytes[7]            = 8'($urandom);
    frame_bytes[POS_LEN_LOW]  = len[7:0];
    frame_bytes[POS_LEN_HIGH] = len[15:8];
    for (i = HEADER_BYTES; i < FRAME_BYTES - 1; i++) begin
      case (fill)
        FILL_ZERO: frame_bytes[i] = 8'h00;
        FILL_ONES: frame_bytes[i] = 8'hFF;
        default:   frame_bytes[i] = 8'($urandom);
      endcase
    end
    sum = 8'h00;
    for (i = SYNC_BYTES; i < FRAME_BYTES - 1; i++) sum = sum + frame_bytes[i];
    delta = 8'($urandom_range(1, 255));
    frame_bytes[FRAME_BYTES-1] = bad_sum ? sum + delta : sum;
    if (damage_at >= 0) frame_bytes[damage_at] = frame_bytes[damage_at] ^ delta;
    for (i = 0; i < FRAME_BYTES; i++) begin
      if ($urandom_range(0, 99) < tick_pct)
        repeat ($urandom_range(1, 4)) send_item(REQ_TICK, 8'($urandom));
      send_item(REQ_BYTE, frame_bytes[i]);
    end
  endtask

  initial begin : stimulus
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [15:0] ticks;
    int          pick;
    int          n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: a clean frame of zeros.
    send_frame(8'h00, 8'h00, FRAME_LEN, -1, 1'b0, FILL_ZERO);

    // Extreme register values, all-ones content, and a bad checksum.
    program_regs(8'hFF, 8'hFF, 16'hFFFF);
    send_frame(8'hFF, 8'hFF, FRAME_LEN, -1, 1'b0, FILL_ONES);
    send_frame(8'hFF, 8'hFF, FRAME_LEN, -1, 1'b1, FILL_RANDOM);

    // A write to the unused index must leave the registers alone.
    settle();
    cfg_write(CFG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;

    // Header errors: address, command, both length bytes, broken sync.
    program_regs(8'h5A, 8'h01, 16'd100);
    send_frame(8'h5B, 8'h01, FRAME_LEN, -1, 1'b0, FILL_RANDOM);
    send_frame(8'h5A, 8'h81, FRAME_LEN, -1, 1'b0, FILL_RANDOM);
    send_frame(8'h5A, 8'h01, FRAME_LEN + 1, -1, 1'b0, FILL_RANDOM);
    send_frame(8'h5A, 8'h01, FRAME_LEN + 16'h0100, -1, 1'b0, FILL_RANDOM);
    send_item(REQ_BYTE, SYNC_BYTE);
    send_item(REQ_BYTE, SYNC_BYTE);
    send_item(REQ_BYTE, 8'h55);
    send_frame(8'h5A, 8'h01, FRAME_LEN, -1, 1'b0, FILL_RANDOM);

    // Idle timeout with a zero limit, including while hunting for sync.
    program_regs(8'h5A, 8'h01, 16'd0);
    send_item(REQ_BYTE, SYNC_BYTE);
    send_item(REQ_TICK, 8'hFF);
    send_item(REQ_BYTE, SYNC_BYTE);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, 8'h00);

    // Limit of two: two ticks pass, three do not.
    program_regs(8'h5A, 8'h01, 16'd2);
    send_item(REQ_BYTE, SYNC_BYTE);
    repeat (2) send_item(REQ_TICK, 8'($urandom));
    send_item(REQ_BYTE, SYNC_BYTE);
    repeat (3) send_item(REQ_TICK, 8'($urandom));
    send_item(REQ_BYTE, SYNC_BYTE);

    // With the full-scale limit a quiet line never times out.
    no_idle = 1'b1;
    program_regs(8'h5A, 8'h01, 16'hFFFF);
    repeat (40) send_item(REQ_TICK, 8'($urandom));
    send_item(REQ_BYTE, 8'h00);
    no_idle = 1'b0;

    // Long receiver hold-off while the sender keeps pushing error-causing bytes.
    program_regs(8'($urandom), 8'($urandom), 16'd100);
    hold_off_request = 1'b1;
    repeat (40) send_item(REQ_BYTE, 8'($urandom_range(0, 8'hA9)));
    settle();

    // Random phase: mostly good frames, some damaged frames and noise.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 2);
        addr = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        pick = $urandom_range(0, 2);
        cmd  = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        case ($urandom_range(0, 6))
          0:       ticks = 16'd0;
          1:       ticks = 16'd1;
          2:       ticks = 16'd2;
          3:       ticks = 16'hFFFF;
          4:       ticks = 16'($urandom);
          default: ticks = 16'd100;
        endcase
        program_regs(addr, cmd, ticks);
      end
      no_idle  = ($urandom_range(0, 5) == 0);
      tick_pct = ($urandom_range(0, 2) == 0) ? 4 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(cur_address, cur_command, FRAME_LEN, -1, 1'b0, FILL_RANDOM);
      end else if (pick < 70) begin
        send_frame(cur_address, cur_command, FRAME_LEN, -1, 1'b1, FILL_RANDOM);
      end else if (pick < 85) begin
        send_frame(cur_address, cur_command, FRAME_LEN,
                   $urandom_range(0, FRAME_BYTES - 1), 1'b0, FILL_RANDOM);
      end else begin
        n = $urandom_range(5, 20);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0)
            send_item(REQ_BYTE, SYNC_BYTE);
          else
            send_item(1'($urandom_range(0, 1)), 8'($urandom));
        end
      end
    end
    no_idle  = 1'b0;
    tick_pct = 0;

    // Drain, allow stragglers to show up, then report.
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
